@@ rtl/kmsct_pkg.sv @@
// Package with shared constants, codes and types of the keyed countdown timer.
package kmsct_pkg;

  localparam int unsigned SlotsDef = 2;
  localparam int unsigned TicksPerSecondDef = 100;

  localparam int unsigned CmdW = 2;
  localparam int unsigned KeyW = 16;
  localparam int unsigned SecW = 17;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgW = 2;

  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_SET   = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CmdW-1:0] CMD_QUERY = 2'd3;

  localparam logic [StatusW-1:0] ST_DONE     = 2'd0;
  localparam logic [StatusW-1:0] ST_RELOADED = 2'd1;
  localparam logic [StatusW-1:0] ST_REJECTED = 2'd2;
  localparam logic [StatusW-1:0] ST_CLAIMED  = 2'd3;

  typedef struct packed {
    logic exec;
    logic cfg_we;
  } kmsct_cmd_t;

endpackage

@@ rtl/kmsct_ctrl.sv @@
// Controller that accepts commands and marks when a result word is presented.
module kmsct_ctrl
  import kmsct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       cfg_we_i,
  output logic       busy,
  output logic       done_o,
  output kmsct_cmd_t cmd_o
);

  localparam logic StIdle   = 1'b0;
  localparam logic StResult = 1'b1;

  logic state_q;
  logic state_d;

  always_comb begin
    busy        = 1'b0;
    cmd_o.exec   = start & ~busy;
    cmd_o.cfg_we = cfg_we_i;
    case (state_q)
      StIdle:   state_d = cmd_o.exec ? StResult : StIdle;
      StResult: state_d = cmd_o.exec ? StResult : StIdle;
      default:  state_d = StIdle;
    endcase
  end

  assign done_o = (state_q == StResult);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/kmsct_datapath.sv @@
// Datapath holding the timer slots, the limit register and the result word.
module kmsct_datapath
  import kmsct_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef,
  parameter int unsigned TICKS_PER_SECOND = TicksPerSecondDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kmsct_cmd_t         cmd_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic [CmdW-1:0]    command_i,
  input  logic [KeyW-1:0]    timer_key_i,
  input  logic [SecW-1:0]    duration_seconds_i,
  input  logic               query_slot_i,
  output logic [StatusW-1:0] status_o,
  output logic               slot_index_o,
  output logic               slot_is_active_o,
  output logic [KeyW-1:0]    slot_key_o,
  output logic [SecW-1:0]    remaining_seconds_o,
  output logic [1:0]         active_count_o,
  output logic [1:0]         expired_mask_o
);

  localparam int unsigned CntW  = $clog2(SLOTS + 1);
  localparam int unsigned AW    = (CntW > CfgW) ? CntW : CfgW;
  localparam int unsigned FracW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int unsigned MaskW = (SLOTS > 2) ? SLOTS : 2;
  localparam logic [FracW-1:0] FracTop = FracW'(TICKS_PER_SECOND - 1);

  // Each slot keeps its ticks as whole seconds plus a sub-second tick count.
  logic [SLOTS-1:0] run_q, run_d;
  logic [KeyW-1:0]  key_q [SLOTS];
  logic [KeyW-1:0]  key_d [SLOTS];
  logic [SecW-1:0]  sec_q [SLOTS];
  logic [SecW-1:0]  sec_d [SLOTS];
  logic [FracW-1:0] frac_q [SLOTS];
  logic [FracW-1:0] frac_d [SLOTS];
  logic [CntW-1:0]  count_q, count_d;
  logic [CfgW-1:0]  allowed_q;

  logic [StatusW-1:0] status_d;
  logic               sidx_d;
  logic               sact_d;
  logic [KeyW-1:0]    skey_d;
  logic [SecW-1:0]    srem_d;
  logic [MaskW-1:0]   emask_d;
  logic               found;

  always_comb begin
    run_d    = run_q;
    key_d    = key_q;
    sec_d    = sec_q;
    frac_d   = frac_q;
    status_d = ST_DONE;
    sidx_d   = 1'b0;
    sact_d   = 1'b0;
    skey_d   = '0;
    srem_d   = '0;
    emask_d  = '0;
    found    = 1'b0;
    count_d  = '0;

    case (command_i)
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (run_q[i]) begin
            if (sec_q[i] == '0 && frac_q[i] <= FracW'(1)) begin
              run_d[i]   = 1'b0;
              emask_d[i] = 1'b1;
            end else if (frac_q[i] == '0) begin
              sec_d[i]  = sec_q[i] - SecW'(1);
              frac_d[i] = FracTop;
            end else begin
              frac_d[i] = frac_q[i] - FracW'(1);
            end
          end
        end
      end
      CMD_SET: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && run_q[i] && key_q[i] == timer_key_i) begin
            found     = 1'b1;
            sec_d[i]  = duration_seconds_i;
            frac_d[i] = '0;
            status_d  = ST_RELOADED;
            sidx_d    = 1'(i);
          end
        end
        if (!found && (AW'(count_q) < AW'(allowed_q))) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && !run_q[i]) begin
              found     = 1'b1;
              run_d[i]  = 1'b1;
              key_d[i]  = timer_key_i;
              sec_d[i]  = duration_seconds_i;
              frac_d[i] = '0;
              status_d  = ST_CLAIMED;
              sidx_d    = 1'(i);
            end
          end
        end
        if (!found) begin
          status_d = ST_REJECTED;
        end
      end
      CMD_CLEAR: begin
        run_d = '0;
      end
      CMD_QUERY: begin
        sidx_d = query_slot_i;
        for (int i = 0; i < SLOTS; i++) begin
          if (int'(query_slot_i) == i && run_q[i]) begin
            sact_d = 1'b1;
            skey_d = key_q[i];
            srem_d = sec_q[i];
          end
        end
      end
      default: begin
        run_d = run_q;
      end
    endcase

    for (int i = 0; i < SLOTS; i++) begin
      count_d = count_d + CntW'(run_d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= '0;
      count_q   <= '0;
      allowed_q <= CfgW'(1);
    end else begin
      if (cmd_i.cfg_we) begin
        allowed_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        run_q   <= run_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      key_q               <= key_d;
      sec_q               <= sec_d;
      frac_q              <= frac_d;
      status_o            <= status_d;
      slot_index_o        <= sidx_d;
      slot_is_active_o    <= sact_d;
      slot_key_o          <= skey_d;
      remaining_seconds_o <= srem_d;
      active_count_o      <= 2'(count_d);
      expired_mask_o      <= emask_d[1:0];
    end
  end

endmodule

@@ rtl/keyed_multi_slot_countdown_timer_core.sv @@
// Top level of the keyed multi-slot countdown timer.
// Every command is accepted without waiting: busy stays low, so a new word can be started
// on every clock edge. The result word of a command appears on the result ports in
// the cycle after it is accepted, marked by done_o for exactly that one cycle, and
// must be captured then since the receiver cannot stall it. The slot table is a set
// of registers updated when a command is accepted. The user must write the limit register
// with cfg_we_i and cfg_wdata_i only while no command is in flight; the block does not check.
module keyed_multi_slot_countdown_timer_core
  import kmsct_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef,
  parameter int unsigned TICKS_PER_SECOND = TicksPerSecondDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic [CmdW-1:0]    command_i,
  input  logic [KeyW-1:0]    timer_key_i,
  input  logic [SecW-1:0]    duration_seconds_i,
  input  logic               query_slot_i,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic               slot_index_o,
  output logic               slot_is_active_o,
  output logic [KeyW-1:0]    slot_key_o,
  output logic [SecW-1:0]    remaining_seconds_o,
  output logic [1:0]         active_count_o,
  output logic [1:0]         expired_mask_o
);

  kmsct_cmd_t cmd;

  kmsct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cfg_we_i (cfg_we_i),
    .busy     (busy),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  kmsct_datapath #(
    .SLOTS            (SLOTS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_wdata_i         (cfg_wdata_i),
    .command_i           (command_i),
    .timer_key_i         (timer_key_i),
    .duration_seconds_i  (duration_seconds_i),
    .query_slot_i        (query_slot_i),
    .status_o            (status_o),
    .slot_index_o        (slot_index_o),
    .slot_is_active_o    (slot_is_active_o),
    .slot_key_o          (slot_key_o),
    .remaining_seconds_o (remaining_seconds_o),
    .active_count_o      (active_count_o),
    .expired_mask_o      (expired_mask_o)
  );

endmodule
